// File: sv/lpfp_pkg.sv
// shared types and constants for the length-prefixed frame parser
package lpfp_pkg;

    // parse phases
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MODE    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_END     = 3'd4
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // framing bytes
    localparam logic [7:0] BYTE_HEADER = 8'hFF;
    localparam logic [7:0] BYTE_END    = 8'hFE;
    localparam logic [7:0] MODE_LOW    = 8'hF9;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] mode;
        logic [7:0] length;
    } result_t;

endpackage

// File: sv/length_prefixed_frame_parser_core.sv
// top level of the length-prefixed frame parser
// a byte waits in the input register; its result then goes to the result register
// throughput: one byte per cycle while the result side keeps up
// the rate is set by the phase update between input and result registers
// reset: rst_n clears both registers' valid flags and returns parsing to header hunting
// held mode, length and payload count reset to zero
module length_prefixed_frame_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] result_kind,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [7:0] frame_mode,
    output logic [7:0] frame_length
);
    import lpfp_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_ready;
    logic       has_result;
    logic       step;
    result_t    result;
    result_t    out_res;

    // stage one: accepted byte waits here for the parser
    lpfp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .take       (step)
    );

    // a byte with no result never waits on the result side; one with a
    // result advances only when the result register can take it
    assign step = held_valid && (!has_result || out_ready);

    // parse state, one byte per step
    lpfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (held_byte),
        .has_result (has_result),
        .result     (result)
    );

    // stage two: result item held until the downstream side takes it
    lpfp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && has_result),
        .result    (result),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .held      (out_res)
    );

    assign result_kind  = out_res.kind;
    assign data_byte    = out_res.data;
    assign byte_index   = out_res.index;
    assign frame_mode   = out_res.mode;
    assign frame_length = out_res.length;

    // only the three defined kinds ever leave the block
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == KIND_DATA || result_kind == KIND_GOOD
                       || result_kind == KIND_BAD))
        else $error("undefined result kind");

    // frame end reports carry zero data and index
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_DATA |-> data_byte == 8'd0 && byte_index == 8'd0)
        else $error("frame end report with nonzero data or index");

    // the input side stalls only when a byte is already waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> held_valid && !step)
        else $error("input stalled with no byte waiting");

endmodule

// File: sv/lpfp_in_reg.sv
// input register holding one received byte
module lpfp_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       held_valid,
    output logic [7:0] held_byte,
    input  logic       take
);
    import lpfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // full and not drained this cycle
    assign in_stall   = valid_reg && !take;
    assign valid_next = (in_valid && !in_stall) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// File: sv/lpfp_parser.sv
// frame parse state and per-byte next-state logic
module lpfp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             has_result,
    output lpfp_pkg::result_t result
);
    import lpfp_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] mode_reg;
    logic [7:0] mode_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        length_next = length_reg;
        count_next  = count_reg;
        has_result  = 1'b0;
        result      = '{kind: KIND_DATA, data: 8'd0, index: 8'd0,
                        mode: mode_reg, length: length_reg};
        case (phase_reg)
            PH_MODE:
            begin
                if (rx_byte >= MODE_LOW)
                begin
                    mode_next  = rx_byte;
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                length_next = rx_byte;
                count_next  = 8'd0;
                phase_next  = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                has_result   = 1'b1;
                result.data  = rx_byte;
                result.index = count_reg;
                count_next   = count_inc;
                // a length of zero wraps to 256 bytes
                if (count_inc == length_reg)
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                has_result  = 1'b1;
                result.kind = (rx_byte == BYTE_END) ? KIND_GOOD : KIND_BAD;
                phase_next  = PH_HEADER;
            end
            default:
            begin
                phase_next = (rx_byte == BYTE_HEADER) ? PH_MODE : PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            mode_reg   <= 8'd0;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            mode_reg   <= mode_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // last payload byte leads to the end check
    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PAYLOAD && count_inc == length_reg
        |=> phase_reg == PH_END)
        else $error("last payload byte did not move to end phase");

    // end phase always returns to header hunting
    a_end_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_END |=> phase_reg == PH_HEADER)
        else $error("end phase did not return to header");

    // payload index stays below the frame length unless length wraps
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD && length_reg != 8'd0 |-> count_reg < length_reg)
        else $error("payload index beyond frame length");

endmodule

// File: sv/lpfp_out_reg.sv
// result register toward the downstream side
module lpfp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lpfp_pkg::result_t result,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output lpfp_pkg::result_t held
);
    import lpfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // empty, or being taken this cycle
    assign ready      = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = res_reg;

endmodule
